@@ hdl/serm_pkg.sv @@
// Shared constants and command/status types for the slotted encoder rpm meter.
// No dependencies; every other file of the block imports this package.
package serm_pkg;

  // Default widths of the internal time and count state
  localparam int unsigned TIME_WIDTH_DEF  = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Fixed payload widths
  localparam int unsigned EDGE_TIME_W = 32;
  localparam int unsigned RPM_W       = 32;
  localparam int unsigned PCOUNT_W    = 16;
  localparam int unsigned WINDOW_W    = 32;
  localparam int unsigned SLOTS_W     = 8;
  localparam int unsigned MIN_WIN_W   = 32;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIN = 2'd1;

  localparam logic [SLOTS_W-1:0]   SLOTS_RST   = 8'd20;
  localparam logic [MIN_WIN_W-1:0] MIN_WIN_RST = 32'd500000;

  // Microseconds per minute, and the bits it needs
  localparam int unsigned        US_PER_MIN_W = 26;
  localparam logic [US_PER_MIN_W-1:0] US_PER_MIN = 26'd60000000;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // take the input beat, update count and report time
    logic mul;       // form numerator and denominator
    logic div_step;  // one restoring division step
    logic load_out;  // move the result into the output register
  } serm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic report;    // the offered edge closes a window
    logic out_free;  // output register can take a result this cycle
  } serm_status_t;

endpackage

@@ hdl/serm_if.sv @@
// Valid/ready channel interfaces for edge beats in and report beats out.
// Depends on serm_pkg for the payload widths.
interface serm_in_if import serm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [EDGE_TIME_W-1:0] edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink   (input valid, input edge_time_us, output ready);
endinterface

interface serm_out_if import serm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RPM_W-1:0]    rpm;
  logic [PCOUNT_W-1:0] pulse_count;
  logic [WINDOW_W-1:0] window_us;

  modport source (output valid, output rpm, output pulse_count, output window_us,
                  input ready);
  modport sink   (input valid, input rpm, input pulse_count, input window_us,
                  output ready);
endinterface

@@ hdl/serm_ctrl.sv @@
// Sequencer for the rpm meter: accept, multiply, divide, hand off.
// Depends on serm_pkg; drives serm_dp through serm_cmd_t.
module serm_ctrl import serm_pkg::*; #(
  parameter int unsigned NUM_W = COUNT_WIDTH_DEF + US_PER_MIN_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  serm_status_t status_i,
  output serm_cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.report) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = CNT_W'(NUM_W - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_OUT: begin
        // hold until the output register frees up
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/serm_dp.sv @@
// Datapath of the rpm meter: config, edge count, report time, divider, output register.
// Depends on serm_pkg; commanded by serm_ctrl.
module serm_dp import serm_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [EDGE_TIME_W-1:0] edge_time_i,
  input  serm_cmd_t              cmd_i,
  output serm_status_t           status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RPM_W-1:0]       rpm_o,
  output logic [PCOUNT_W-1:0]    pulse_count_o,
  output logic [WINDOW_W-1:0]    window_o
);

  localparam int unsigned NUM_W = COUNT_WIDTH + US_PER_MIN_W;
  localparam int unsigned DEN_W = TIME_WIDTH + SLOTS_W;

  logic [SLOTS_W-1:0]     slots_q;
  logic [MIN_WIN_W-1:0]   min_win_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [TIME_WIDTH-1:0]  last_q;
  logic [COUNT_WIDTH-1:0] rep_count_q;
  logic [TIME_WIDTH-1:0]  rep_elapsed_q;
  logic [NUM_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W-1:0]       rem_q;
  logic                   out_valid_q;
  logic [RPM_W-1:0]       rpm_q;
  logic [PCOUNT_W-1:0]    pcount_q;
  logic [WINDOW_W-1:0]    window_q;

  logic [TIME_WIDTH-1:0]  now;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [DEN_W:0]         trial;
  logic [DEN_W:0]         diff;
  logic                   qbit;
  logic [RPM_W-1:0]       rpm_sat;

  assign now       = TIME_WIDTH'(edge_time_i);
  assign elapsed   = now - last_q;
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  assign status_o.report   = 64'(elapsed) > 64'(min_win_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // restoring division step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = !diff[DEN_W];

  // zero slots gives a zero denominator; report rpm 0 then
  assign rpm_sat = (den_q == '0)                ? '0 :
                   (num_q[NUM_W-1:RPM_W] != '0) ? '1 : num_q[RPM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q   <= SLOTS_RST;
      min_win_q <= MIN_WIN_RST;
      count_q   <= '0;
      last_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SLOTS) begin
        slots_q <= cfg_data_i[SLOTS_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_MIN_WIN) begin
        min_win_q <= cfg_data_i[MIN_WIN_W-1:0];
      end
      if (cmd_i.accept) begin
        if (status_o.report) begin
          count_q <= '0;
          last_q  <= now;
        end else begin
          count_q <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.report) begin
      rep_count_q   <= count_inc;
      rep_elapsed_q <= elapsed;
    end
    if (cmd_i.mul) begin
      num_q <= NUM_W'(rep_count_q) * NUM_W'(US_PER_MIN);
      den_q <= DEN_W'(slots_q) * DEN_W'(rep_elapsed_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], qbit};
    end
    if (cmd_i.load_out) begin
      rpm_q    <= rpm_sat;
      pcount_q <= (64'(rep_count_q) > 64'({PCOUNT_W{1'b1}})) ?
                  '1 : PCOUNT_W'(rep_count_q);
      window_q <= (64'(rep_elapsed_q) > 64'({WINDOW_W{1'b1}})) ?
                  '1 : WINDOW_W'(rep_elapsed_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rpm_o         = rpm_q;
  assign pulse_count_o = pcount_q;
  assign window_o      = window_q;

endmodule

@@ hdl/slotted_encoder_rpm_meter.sv @@
// Top level of the slotted encoder rpm meter: controller plus datapath.
// Depends on serm_pkg, serm_if, serm_ctrl and serm_dp.
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  -------------------------------------
//  in_i     in   valid / ready    edge_time_us[31:0]
//  out_o    out  valid / ready    rpm[31:0], pulse_count[15:0], window_us[31:0]
//  cfg      in   cfg_we_i only    cfg_idx_i (0 slots, 1 min window), cfg_data_i
//
// An edge that does not close a window is only counted; the next beat is taken
// in the following cycle.
// An edge that closes a window goes through accept, a multiply step, COUNT_WIDTH + 26
// restoring divider steps at one quotient bit each, and a hand-off into the output
// register.
// Reset clears the edge count and the report time and loads slots 20 and
// window 500000 us; there is no clearing pass.
// A stalled output holds its beat while the next edges are still counted; a
// further report waits in the hand-off step until the output beat is taken.
module slotted_encoder_rpm_meter import serm_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  serm_in_if.sink               in_i,
  serm_out_if.source            out_o
);

  localparam int unsigned NUM_W = COUNT_WIDTH + US_PER_MIN_W;

  serm_cmd_t    cmd;
  serm_status_t status;

  // sequence one window report at a time
  serm_ctrl #(
    .NUM_W (NUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // count edges, time the window, divide, and hold the output beat
  serm_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .edge_time_i   (in_i.edge_time_us),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .rpm_o         (out_o.rpm),
    .pulse_count_o (out_o.pulse_count),
    .window_o      (out_o.window_us)
  );

endmodule

@@ hdl/serm_checker.sv @@
// Port-level checks for slotted_encoder_rpm_meter, attached by bind.
// Depends on serm_pkg for payload widths.
module serm_checker import serm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [RPM_W-1:0]    rpm_i,
  input logic [PCOUNT_W-1:0] pulse_count_i,
  input logic [WINDOW_W-1:0] window_i
);

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // a stalled beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(rpm_i) && $stable(pulse_count_i) && $stable(window_i))
    else $error("output payload changed while stalled");

  // the closing edge is part of its window, so a report counts at least one edge
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pulse_count_i != '0)
    else $error("report with zero edges");

  // a report needs a window longer than the minimum, so the window is never zero
  a_window_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> window_i != '0)
    else $error("report with zero window");

endmodule

bind slotted_encoder_rpm_meter serm_checker u_serm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .rpm_i         (out_o.rpm),
  .pulse_count_i (out_o.pulse_count),
  .window_i      (out_o.window_us)
);

@@ verif/slotted_encoder_rpm_meter_tb.sv @@
// Self-checking testbench for the slotted encoder rpm meter.
// Depends on serm_pkg, the serm_in_if / serm_out_if channels and the block's RTL.
`timescale 1ns / 100ps

module slotted_encoder_rpm_meter_tb;
  import serm_pkg::*;

  // Indexes past the two real registers; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Cycles to let pass after the last report so an edge still in flight lands
  localparam int unsigned DRAIN_CYCLES = 60;
  // Long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_OFF_CYCLES = 600;

  typedef struct packed {
    logic [RPM_W-1:0]    rpm;
    logic [PCOUNT_W-1:0] pulses;
    logic [WINDOW_W-1:0] window;
  } tach_report_t;

  // Tracks the meter's count, report time and registers, and holds the
  // reports it must emit in order.
  class rpm_scoreboard;
    logic [SLOTS_W-1:0]     slots;
    logic [MIN_WIN_W-1:0]   min_win;
    logic [PCOUNT_W-1:0]    edges_seen;
    logic [EDGE_TIME_W-1:0] last_t;
    tach_report_t           pending[$];
    int unsigned            errors;

    function new();
      slots      = SLOTS_RST;
      min_win    = MIN_WIN_RST;
      edges_seen = '0;
      last_t     = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_SLOTS) begin
        slots = d[SLOTS_W-1:0];
      end else if (idx == CFG_MIN_WIN) begin
        min_win = d[MIN_WIN_W-1:0];
      end
    endfunction

    // Revolutions per minute over the window, floored and clamped to 32 bits
    function logic [RPM_W-1:0] rpm_of(logic [PCOUNT_W-1:0] n, logic [WINDOW_W-1:0] dt,
                                      logic [SLOTS_W-1:0] s);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      if (dt == '0 || s == '0) return '0;
      num = 64'(n) * 64'(US_PER_MIN);
      den = 64'(s) * 64'(dt);
      q   = num / den;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function void note_edge(logic [EDGE_TIME_W-1:0] t);
      logic [WINDOW_W-1:0] dt;
      tach_report_t        r;
      dt = t - last_t;
      if (edges_seen != '1) edges_seen++;
      if (dt > min_win) begin
        r.rpm    = rpm_of(edges_seen, dt, slots);
        r.pulses = edges_seen;
        r.window = dt;
        pending.push_back(r);
        edges_seen = '0;
        last_t     = t;
      end
    endfunction

    function void check_report(logic [RPM_W-1:0] rpm, logic [PCOUNT_W-1:0] pulses,
                               logic [WINDOW_W-1:0] window);
      tach_report_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: rpm %0d pulses %0d window %0d",
                 $time, rpm, pulses, window);
        return;
      end
      exp_r = pending.pop_front();
      if (rpm !== exp_r.rpm) begin
        errors++;
        $display("%0t: rpm expected %0d actual %0d", $time, exp_r.rpm, rpm);
      end
      if (pulses !== exp_r.pulses) begin
        errors++;
        $display("%0t: pulse_count expected %0d actual %0d", $time, exp_r.pulses, pulses);
      end
      if (window !== exp_r.window) begin
        errors++;
        $display("%0t: window_us expected %0d actual %0d", $time, exp_r.window, window);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  serm_in_if  in_ch ();
  serm_out_if out_ch ();

  slotted_encoder_rpm_meter dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  rpm_scoreboard sb = new();

  // Idling switches for each side, and a one-shot request for a long hold-off
  bit tx_idle;
  bit rx_idle;
  bit squeeze_req;
  // Running timestamp of the well-formed edge stream
  logic [EDGE_TIME_W-1:0] cur_t;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: one ready assignment per falling edge. A stall counts down here,
  // so the sender keeps offering beats while the output is held off.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every report beat at the rising edge it is taken
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_report(out_ch.rpm, out_ch.pulse_count, out_ch.window_us);
    end
  end

  // Offer one edge beat, hold it until taken, and log it for prediction.
  // Entered and left at a falling edge.
  task automatic send_edge(input logic [EDGE_TIME_W-1:0] t);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.edge_time_us <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_edge(t);
    @(negedge clk_i);
  endtask

  // Register write: one cycle with the enable high, then the enable low again before
  // the task returns, so that back-to-back writes never share a time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, d);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending report, then let a late edge finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One random setting, then a stream of edges. Most edges advance a running
  // time by a fraction of the window so reports come every few edges; the
  // rest repeat the report time (zero window) or jump anywhere.
  task automatic run_phase(input int unsigned n_items, input bit squeeze);
    logic [SLOTS_W-1:0]     slots;
    logic [MIN_WIN_W-1:0]   min_win;
    logic [EDGE_TIME_W-1:0] t;
    logic [31:0]            step;
    settle();
    case ($urandom_range(0, 9))
      0: slots = 8'd1;
      1: slots = 8'd255;
      2: slots = 8'd0;
      default: slots = 8'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 3))
      0: min_win = 32'd0;
      1: min_win = $urandom_range(1, 64);
      2: min_win = $urandom_range(100, 5000);
      default: min_win = $urandom;
    endcase
    if (squeeze) min_win = 32'd0;
    // junk in the upper data bits must be dropped by the slots register
    write_reg(CFG_SLOTS, {24'($urandom), slots});
    write_reg(CFG_MIN_WIN, min_win);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    end
    step = min_win / 3 + 32'd8;
    if (squeeze) squeeze_req = 1'b1;
    repeat (n_items) begin
      case ($urandom_range(0, 9))
        0: t = $urandom;
        1: t = sb.last_t;
        default: t = cur_t + $urandom_range(0, step);
      endcase
      cur_t = t;
      send_edge(t);
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_SLOTS;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.edge_time_us = '0;
    tx_idle            = 1'b1;
    rx_idle            = 1'b1;
    squeeze_req        = 1'b0;
    cur_t              = $urandom;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: 20 slots, 500 ms window
    send_edge(32'd0);             // zero window, counted only
    send_edge(32'd500000);        // equal to the window, not past it
    send_edge(32'd500001);        // closes the window, counting every edge since reset
    send_edge(32'hFFFF_FFFF);     // long window
    send_edge(32'd500000);        // window wraps through zero
    settle();

    // One slot, no minimum window
    write_reg(CFG_SLOTS, 32'd1);
    write_reg(CFG_MIN_WIN, 32'd0);
    send_edge(sb.last_t);                  // zero window never reports
    send_edge(sb.last_t + 32'd1);          // shortest window
    send_edge(sb.last_t + 32'hFFFF_FFFF);  // longest window, rpm floors to 0
    settle();

    // Most slots on the wheel
    write_reg(CFG_SLOTS, 32'd255);
    send_edge(sb.last_t + 32'd1);
    settle();

    // Zero slots gives rpm 0; spare indexes must not disturb anything
    write_reg(CFG_SLOTS, 32'hFFFF_FF00);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    send_edge(sb.last_t + 32'd1000);
    settle();

    // rpm clamp boundary: in 1 us, the most edges that still fit in 32 bits, then one more
    write_reg(CFG_SLOTS, 32'd1);
    repeat (70) send_edge(sb.last_t);
    send_edge(sb.last_t + 32'd1);
    repeat (71) send_edge(sb.last_t);
    send_edge(sb.last_t + 32'd1);
    settle();

    // Random settings; the third phase holds the output off for a long time
    for (int k = 0; k < 8; k++) begin
      run_phase(77, k == 2);
    end
    // Final stretch at full rate on both sides
    settle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_phase(77, 1'b0);

    // Drain, bounded so a lost report is charged here
    in_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d reports expected but never seen", $time, sb.pending.size());
      sb.errors += sb.pending.size();
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
